>>> src/bsc_pkg.sv
`timescale 1ns / 1ps

package bsc_pkg;

    // parser phase of the element walk
    typedef enum logic [1:0] {
        PH_ID   = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } bsc_phase_t;

    // security class codes
    typedef enum logic [1:0] {
        CLS_OPEN = 2'd0,
        CLS_WEP  = 2'd1,
        CLS_WPA  = 2'd2,
        CLS_WPA2 = 2'd3
    } bsc_class_t;

    localparam logic [7:0] ID_RSN    = 8'd48;
    localparam logic [7:0] ID_VENDOR = 8'd221;

    // body bytes tracked for the vendor oui/type check
    localparam logic [2:0] OUI_LEN = 3'd4;

    // one input transfer, as held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       empty_item;
        logic       privacy;
        logic       last_item;
    } bsc_item_t;

    function automatic logic [7:0] wpa_oui_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h00;
            2'd1:    val = 8'h50;
            2'd2:    val = 8'hF2;
            2'd3:    val = 8'h01;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

>>> src/bsc_parser.sv
`timescale 1ns / 1ps

module bsc_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  bsc_pkg::bsc_item_t  item,
    output bsc_pkg::bsc_class_t security_class
);
    import bsc_pkg::*;

    bsc_phase_t phase_reg, phase_next;
    logic [7:0] element_id_reg, element_id_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [2:0] body_position_reg, body_position_next;
    logic       oui_match_reg, oui_match_next;
    logic       rsn_seen_reg, rsn_seen_next;
    logic       wpa_seen_reg, wpa_seen_next;

    logic [7:0] left_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_ID;
            element_id_reg    <= 8'd0;
            bytes_left_reg    <= 8'd0;
            body_position_reg <= 3'd0;
            oui_match_reg     <= 1'b0;
            rsn_seen_reg      <= 1'b0;
            wpa_seen_reg      <= 1'b0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            element_id_reg    <= element_id_next;
            bytes_left_reg    <= bytes_left_next;
            body_position_reg <= body_position_next;
            oui_match_reg     <= oui_match_next;
            rsn_seen_reg      <= rsn_seen_next;
            wpa_seen_reg      <= wpa_seen_next;
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        element_id_next    = element_id_reg;
        bytes_left_next    = bytes_left_reg;
        body_position_next = body_position_reg;
        oui_match_next     = oui_match_reg;
        rsn_seen_next      = rsn_seen_reg;
        wpa_seen_next      = wpa_seen_reg;
        left_dec           = bytes_left_reg - 8'd1;

        if (!item.empty_item)
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    bytes_left_next    = item.data_byte;
                    body_position_next = 3'd0;
                    oui_match_next     = 1'b1;
                    if (item.data_byte == 8'd0)
                    begin
                        // zero-length element completes here, too short for vendor match
                        phase_next = PH_ID;
                        if (element_id_reg == ID_RSN)
                            rsn_seen_next = 1'b1;
                    end
                    else
                        phase_next = PH_BODY;
                end
                PH_BODY:
                begin
                    if (body_position_reg < OUI_LEN)
                    begin
                        if (item.data_byte != wpa_oui_byte(body_position_reg[1:0]))
                            oui_match_next = 1'b0;
                        body_position_next = body_position_reg + 3'd1;
                    end
                    bytes_left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        phase_next = PH_ID;
                        if (element_id_reg == ID_RSN)
                            rsn_seen_next = 1'b1;
                        if (element_id_reg == ID_VENDOR && body_position_next >= OUI_LEN
                            && oui_match_next)
                            wpa_seen_next = 1'b1;
                    end
                end
                default:
                begin
                    element_id_next = item.data_byte;
                    phase_next      = PH_LEN;
                end
            endcase
        end

        if (!item.privacy)
            security_class = CLS_OPEN;
        else if (rsn_seen_next)
            security_class = CLS_WPA2;
        else if (wpa_seen_next)
            security_class = CLS_WPA;
        else
            security_class = CLS_WEP;

        // frame end drops everything, including a truncated element
        if (item.last_item)
        begin
            phase_next         = PH_ID;
            element_id_next    = 8'd0;
            bytes_left_next    = 8'd0;
            body_position_next = 3'd0;
            oui_match_next     = 1'b0;
            rsn_seen_next      = 1'b0;
            wpa_seen_next      = 1'b0;
        end
    end

endmodule

>>> src/beacon_security_classify_unit.sv
`timescale 1ns / 1ps

// beacon security classifier: takes the tagged-element region of a beacon one
// byte per transfer and walks it as id / length / body elements; a complete rsn
// element (id 48) marks wpa2, a complete vendor element (id 221) whose body starts
// 00 50 f2 01 marks wpa. the transfer with last_item high ends the frame and gives
// exactly one security_class (open when privacy is clear, else wpa2, wpa or wep);
// all other transfers give none, and a truncated final element is ignored. a
// transfer with empty_item high carries no byte but can still end the frame.
// throughput is one transfer per cycle unless the input register holds back: the
// per-byte parser step is combinational logic between the input register and the
// parser state. security_class is registered: the last item's transfer loads the
// input register, and the result register loads from it once the output is free.
// the input register only holds back while a finished class waits in the output
// register and the held item is itself a frame end.

module beacon_security_classify_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                empty_item,
    input  logic                privacy,
    input  logic                last_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          security_class
);
    import bsc_pkg::*;

    // input register stage
    logic       s1_valid_reg;
    bsc_item_t  s1_item_reg;

    // result register stage
    logic       out_valid_reg;
    bsc_class_t out_class_reg;

    logic       out_free;
    logic       s1_fire;
    bsc_class_t class_now;

    // output slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;
    // a non-last item never needs the output slot
    assign s1_fire  = s1_valid_reg && (!s1_item_reg.last_item || out_free);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_item_reg.data_byte  <= data_byte;
            s1_item_reg.empty_item <= empty_item;
            s1_item_reg.privacy    <= privacy;
            s1_item_reg.last_item  <= last_item;
        end
    end

    bsc_parser u_parser
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (s1_fire),
        .item           (s1_item_reg),
        .security_class (class_now)
    );

    // result register: loaded on a frame-end transfer out of stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_fire && s1_item_reg.last_item;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_fire && s1_item_reg.last_item)
            out_class_reg <= class_now;
    end

    assign out_valid      = out_valid_reg;
    assign security_class = out_class_reg;

endmodule

>>> src/bsc_checker.sv
`timescale 1ns / 1ps

module bsc_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] security_class
);

    // nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid right after reset");

    // input only stalls behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output backpressure");

    // a new result follows a cycle in which input could move
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_ready))
        else $error("result appeared without pipeline advance");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(security_class)))
        else $error("stalled result changed");

    // a waiting input transfer is not withdrawn
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |=> in_valid)
        else $error("input valid dropped before transfer");

endmodule

bind beacon_security_classify_unit bsc_checker u_bsc_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .security_class (security_class)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps

// beacon security classifier bench
// - frames of tag bytes go in through the valid/ready input channel
// - a class-level model walks the same elements and queues the class each frame should get
// - every security_class transfer is compared against the oldest queued class

module tb_top;

    import bsc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int ITEMS_PER_PHASE = 350;

    // element walk model plus the queue of classes still owed by the block
    class beacon_class_scoreboard;
        bsc_phase_t  phase;
        logic [7:0]  elem_id;
        logic [7:0]  bytes_left;
        logic [2:0]  body_pos;
        logic        oui_ok;
        logic        rsn_seen;
        logic        wpa_seen;
        logic [7:0]  oui_pattern [4];
        bsc_class_t  expected_classes [$];
        int          mismatches;

        function new();
            oui_pattern = '{8'h00, 8'h50, 8'hF2, 8'h01};
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            phase = PH_ID;
            elem_id = 8'd0;
            bytes_left = 8'd0;
            body_pos = 3'd0;
            oui_ok = 1'b0;
            rsn_seen = 1'b0;
            wpa_seen = 1'b0;
        endfunction

        function void close_element();
            if (elem_id == ID_RSN)
                rsn_seen = 1'b1;
            if (elem_id == ID_VENDOR && body_pos >= OUI_LEN && oui_ok)
                wpa_seen = 1'b1;
            phase = PH_ID;
        endfunction

        function void parse_byte(input logic [7:0] b);
            case (phase)
                PH_LEN:
                begin
                    bytes_left = b;
                    body_pos = 3'd0;
                    oui_ok = 1'b1;
                    if (b == 8'd0)
                        close_element();
                    else
                        phase = PH_BODY;
                end
                PH_BODY:
                begin
                    if (body_pos < OUI_LEN)
                    begin
                        if (b != oui_pattern[body_pos[1:0]])
                            oui_ok = 1'b0;
                        body_pos = body_pos + 3'd1;
                    end
                    bytes_left = bytes_left - 8'd1;
                    if (bytes_left == 8'd0)
                        close_element();
                end
                default:
                begin
                    elem_id = b;
                    phase = PH_LEN;
                end
            endcase
        endfunction

        // called for every accepted input transfer
        function void note_transfer(input logic [7:0] b, input logic e, input logic p,
                                    input logic l);
            bsc_class_t cls;
            if (!e)
                parse_byte(b);
            if (l)
            begin
                if (!p)
                    cls = CLS_OPEN;
                else if (rsn_seen)
                    cls = CLS_WPA2;
                else if (wpa_seen)
                    cls = CLS_WPA;
                else
                    cls = CLS_WEP;
                expected_classes.push_back(cls);
                clear_frame();
            end
        endfunction

        // called for every accepted output transfer
        function void check_class(input logic [1:0] got);
            bsc_class_t want;
            if (expected_classes.size() == 0)
            begin
                $error("security_class: expected none, actual %0d", got);
                mismatches++;
            end
            else
            begin
                want = expected_classes.pop_front();
                if (got !== want)
                begin
                    $error("security_class: expected %0d (%s), actual %0d",
                           want, want.name(), got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       empty_item;
    logic       privacy;
    logic       last_item;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] security_class;

    beacon_class_scoreboard sb;

    int         idle_pct;       // sender idle chance per cycle
    int         stall_pct;      // receiver stall chance per cycle
    int         hold_req;       // long receiver hold-off, posted by the stimulus
    int         hold_left;      // hold-off cycles still to run, owned by the receiver
    int         items_sent;
    int         cycle_count;
    logic [7:0] frame_bytes [$];

    beacon_security_classify_unit i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .empty_item     (empty_item),
        .privacy        (privacy),
        .last_item      (last_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .security_class (security_class)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver: random stalls, or a long counted hold-off when one is posted
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // both channels are observed at the rising edge, before the block updates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_transfer(data_byte, empty_item, privacy, last_item);
            if (out_valid && out_ready)
                sb.check_class(security_class);
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // offer one transfer; called and returning at a falling edge, valid left high
    task automatic send_item(input logic [7:0] b, input logic e, input logic p, input logic l);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        empty_item <= e;
        privacy    <= p;
        last_item  <= l;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        items_sent++;
    endtask

    // drop valid, wait until every owed class has come out, then idle before returning
    task automatic wait_for_classes();
        in_valid <= 1'b0;
        while (sb.expected_classes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    // one id/length/body element of a random flavor appended to frame_bytes
    task automatic append_element();
        int kind;
        int len;
        int idx;
        int bad;
        kind = $urandom_range(9);
        case (kind)
            0, 1:
            begin
                frame_bytes.push_back(ID_RSN);
                len = $urandom_range(0, 6);
            end
            2, 3, 4:
            begin
                frame_bytes.push_back(ID_VENDOR);
                len = $urandom_range(4, 8);
            end
            5:
            begin
                frame_bytes.push_back(ID_VENDOR);
                len = $urandom_range(0, 3);
            end
            default:
            begin
                frame_bytes.push_back(8'($urandom_range(255)));
                len = $urandom_range(0, 6);
            end
        endcase
        if ($urandom_range(39) == 0)
            len = $urandom_range(9, 255);
        frame_bytes.push_back(8'(len));
        // vendor bodies start with the wpa oui/type, now and then with one bit flipped
        bad = ($urandom_range(2) == 0) ? $urandom_range(3) : -1;
        for (idx = 0; idx < len; idx++)
        begin
            if (kind >= 2 && kind <= 5 && idx < 4)
                frame_bytes.push_back(sb.oui_pattern[idx] ^
                                      ((idx == bad) ? (8'd1 << $urandom_range(7)) : 8'd0));
            else
                frame_bytes.push_back(8'($urandom_range(255)));
        end
    endtask

    // send frame_bytes with stray empty transfers; the frame ends on its last byte
    // or on a trailing empty transfer
    task automatic send_frame(input logic priv);
        int  idx;
        logic end_on_empty;
        end_on_empty = (frame_bytes.size() == 0) || ($urandom_range(3) == 0);
        for (idx = 0; idx < frame_bytes.size(); idx++)
        begin
            while ($urandom_range(15) == 0)
                send_item(8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)), 1'b0);
            if (!end_on_empty && idx == frame_bytes.size() - 1)
                send_item(frame_bytes[idx], 1'b0, priv, 1'b1);
            else
                send_item(frame_bytes[idx], 1'b0, 1'($urandom_range(1)), 1'b0);
        end
        if (end_on_empty)
            send_item(8'($urandom_range(255)), 1'b1, priv, 1'b1);
    endtask

    task automatic send_random_frame();
        int n;
        int keep;
        logic priv;
        frame_bytes.delete();
        priv = ($urandom_range(99) < 80);
        if ($urandom_range(7) == 0)
        begin
            // noise: raw bytes with no element structure
            n = $urandom_range(1, 12);
            repeat (n) frame_bytes.push_back(8'($urandom_range(255)));
        end
        else
        begin
            n = $urandom_range(0, 4);
            repeat (n) append_element();
            // truncated final element
            if (frame_bytes.size() > 0 && $urandom_range(5) == 0)
            begin
                keep = $urandom_range(frame_bytes.size() - 1);
                while (frame_bytes.size() > keep)
                    void'(frame_bytes.pop_back());
            end
        end
        send_frame(priv);
    endtask

    initial
    begin
        int phase_idx;
        int target;
        int idle_modes  [4];
        int stall_modes [4];

        idle_modes  = '{0, 88, 0, 26};
        stall_modes = '{0, 0, 88, 26};
        sb = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = 8'd0;
        empty_item = 1'b0;
        privacy    = 1'b0;
        last_item  = 1'b0;
        out_ready  = 1'b0;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_req   = 0;
        hold_left  = 0;
        items_sent = 0;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty tag region, privacy set: wep
        send_item(8'hFF, 1'b1, 1'b1, 1'b1);
        // zero-length rsn finishing on the last transfer's byte: wpa2
        send_item(ID_RSN, 1'b0, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1, 1'b1);
        // zero-length vendor element never counts: wep
        send_item(ID_VENDOR, 1'b0, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1, 1'b1);
        // complete wpa vendor element, byte on the last transfer: wpa
        send_item(ID_VENDOR, 1'b0, 1'b0, 1'b0);
        send_item(8'h04, 1'b0, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0, 1'b0);
        send_item(8'h50, 1'b0, 1'b0, 1'b0);
        send_item(8'hF2, 1'b0, 1'b0, 1'b0);
        send_item(8'h01, 1'b0, 1'b1, 1'b1);
        // truncated rsn is ignored: wep
        send_item(ID_RSN, 1'b0, 1'b0, 1'b0);
        send_item(8'h05, 1'b0, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1, 1'b1);
        // rsn and wpa both present but privacy clear: open
        send_item(ID_RSN, 1'b0, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1, 1'b0);
        send_item(ID_VENDOR, 1'b0, 1'b1, 1'b0);
        send_item(8'h04, 1'b0, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1, 1'b0);
        send_item(8'h50, 1'b0, 1'b1, 1'b0);
        send_item(8'hF2, 1'b0, 1'b1, 1'b0);
        send_item(8'h01, 1'b0, 1'b1, 1'b0);
        send_item(8'hAA, 1'b1, 1'b0, 1'b1);
        wait_for_classes();

        for (phase_idx = 0; phase_idx < 4; phase_idx++)
        begin
            idle_pct  = idle_modes[phase_idx];
            stall_pct = stall_modes[phase_idx];
            if (phase_idx == 0)
            begin
                // hold the output off long enough that one-transfer frames back up the input
                in_valid <= 1'b0;
                @(posedge clk);
                hold_req = 150;
                @(negedge clk);
                repeat (24) send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b1);
            end
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
                send_random_frame();
            // sender pauses until every class is out
            wait_for_classes();
        end

        if (sb.mismatches == 0 && sb.expected_classes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
